// ===== rtl/core/kscl_pkg.sv =====
// ----------------------------------------------------------------------------
// kscl_pkg
// Types and constants shared by the keyed slot cache and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package kscl_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int KEY_W      = 48;
  localparam int STAMP_W    = 32;

  localparam int S_TDATA_W  = 56;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 16;
  localparam int M_TUSER_W  = 3;

  typedef enum logic [1:0] {
    OP_PUBLISH = 2'd0,
    OP_INV_KEY = 2'd1,
    OP_INV_ALL = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_PUBLISHED = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_NO_TAG    = 3'd2,
    ST_ZERO_KEY  = 3'd3,
    ST_INV_DONE  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [KEY_W-1:0]   key;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/kscl_ram.sv =====
// ----------------------------------------------------------------------------
// kscl_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kscl_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/keyed_slot_cache_lru.sv =====
// ----------------------------------------------------------------------------
// keyed_slot_cache_lru
// Fully associative slot table keyed by 48-bit keys, least recently
// published replacement.
// ----------------------------------------------------------------------------
// Keys and last-use stamps live in one slot RAM with a single read port, so
// a publish that passes its checks and an invalidate of one key scan the
// table one slot per cycle, through S_SCAN and S_LAST to S_COMMIT, where the
// result is registered once the output is free. No new request is taken
// until that commit. Refused publishes, invalidate-all and the unused opcode
// skip the scan and go straight to S_COMMIT. Valid and plot flags sit in
// flip-flops and are cleared by reset, so no clearing pass is needed.
// A waiting result is held in the output register while the next request is
// accepted.
`default_nettype none

module keyed_slot_cache_lru (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // key[47:0], ready_req[48], tag_present[49], with_plot[50], zero above
  input  wire logic [kscl_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // op[1:0]
  input  wire logic [kscl_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // slot_index[2:0], hit[3], evicted[4], any_cleared[5], valid_count[9:6],
  // plot_count[13:10], zero above
  output logic      [kscl_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status[2:0]
  output logic      [kscl_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  import kscl_pkg::*;

  state_e state_q, state_d;

  logic [IDX_W-1:0]   scan_q;
  logic               cmp_vld_q;
  logic [IDX_W-1:0]   cmp_idx_q;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [SLOT_COUNT-1:0] plot_q, plot_d;
  logic [CNT_W-1:0]   vcnt_q, vcnt_d;
  logic [CNT_W-1:0]   pcnt_q, pcnt_d;
  logic [STAMP_W-1:0] tick_q;
  logic               out_vld_q;

  logic               found_q, inv_seen_q, have_min_q, cleared_q;
  logic [IDX_W-1:0]   found_idx_q, inv_idx_q, min_idx_q;
  logic [STAMP_W-1:0] min_stamp_q;

  op_e                op_q;
  logic [KEY_W-1:0]   key_q;
  logic               rdy_q, tag_q, with_plot_q;

  status_e            res_status_q;
  logic [IDX_W-1:0]   res_idx_q;
  logic               res_hit_q, res_evict_q, res_clr_q;
  logic [CNT_W-1:0]   res_vcnt_q, res_pcnt_q;

  logic               accept;
  logic               in_ok;
  logic               need_scan;
  logic               ram_rd_en;
  logic               commit_go;
  logic               pub_ok;
  entry_t             rd_entry;
  entry_t             wr_entry;
  logic               cmp_slot_v;
  logic               cmp_match;
  logic               inv_hit;
  logic [IDX_W-1:0]   pick;
  logic               pick_old_plot;
  logic               do_evict;
  status_e            status_c;
  logic               cleared_c;
  logic [STAMP_W-1:0] tick_next;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign in_ok  = s_axis_tdata[KEY_W] && s_axis_tdata[KEY_W+1] &&
                  (s_axis_tdata[KEY_W-1:0] != '0);
  assign need_scan = (op_e'(s_axis_tuser) == OP_INV_KEY) ||
                     ((op_e'(s_axis_tuser) == OP_PUBLISH) && in_ok);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = need_scan ? S_SCAN : S_COMMIT;
        end
      end
      S_SCAN: begin
        if (scan_q == IDX_W'(SLOT_COUNT - 1)) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (commit_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_rd_en     = 1'b0;
    commit_go     = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      S_SCAN: begin
        ram_rd_en = 1'b1;
      end
      S_COMMIT: begin
        commit_go = !out_vld_q || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  kscl_ram #(
    .Width($bits(entry_t)),
    .Depth(SLOT_COUNT)
  ) u_slot_ram (
    .clk_i    (clk_i),
    .wr_en_i  (commit_go && pub_ok),
    .wr_addr_i(pick),
    .wr_data_i(wr_entry),
    .rd_en_i  (ram_rd_en),
    .rd_addr_i(scan_q),
    .rd_data_o(rd_entry)
  );

  assign pub_ok     = (op_q == OP_PUBLISH) && rdy_q && tag_q && (key_q != '0);
  assign cmp_slot_v = valid_q[cmp_idx_q];
  assign cmp_match  = rd_entry.key == key_q;
  assign inv_hit    = cmp_vld_q && (op_q == OP_INV_KEY) && cmp_slot_v && cmp_match;
  assign tick_next  = tick_q + STAMP_W'(1);
  assign do_evict   = !found_q && !inv_seen_q;

  always_comb begin
    if (found_q) begin
      pick = found_idx_q;
    end else if (inv_seen_q) begin
      pick = inv_idx_q;
    end else begin
      pick = min_idx_q;
    end
  end

  assign pick_old_plot  = valid_q[pick] && plot_q[pick];
  assign wr_entry.key   = key_q;
  assign wr_entry.stamp = tick_next;

  always_comb begin
    status_c  = ST_INV_DONE;
    cleared_c = 1'b0;
    case (op_q)
      OP_PUBLISH: begin
        if (!rdy_q) begin
          status_c = ST_NOT_READY;
        end else if (!tag_q) begin
          status_c = ST_NO_TAG;
        end else if (key_q == '0) begin
          status_c = ST_ZERO_KEY;
        end else begin
          status_c = ST_PUBLISHED;
        end
      end
      OP_INV_KEY: begin
        cleared_c = cleared_q;
      end
      OP_INV_ALL: begin
        cleared_c = |valid_q;
      end
      default: begin
        cleared_c = 1'b0;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    plot_d  = plot_q;
    vcnt_d  = vcnt_q;
    pcnt_d  = pcnt_q;
    if (inv_hit) begin
      valid_d[cmp_idx_q] = 1'b0;
      plot_d[cmp_idx_q]  = 1'b0;
      vcnt_d = vcnt_q - CNT_W'(1);
      pcnt_d = pcnt_q - CNT_W'(plot_q[cmp_idx_q]);
    end
    if (commit_go && pub_ok) begin
      valid_d[pick] = 1'b1;
      plot_d[pick]  = with_plot_q;
      vcnt_d = vcnt_q + CNT_W'(!valid_q[pick]);
      pcnt_d = pcnt_q - CNT_W'(pick_old_plot) + CNT_W'(with_plot_q);
    end
    if (commit_go && (op_q == OP_INV_ALL)) begin
      valid_d = '0;
      plot_d  = '0;
      vcnt_d  = '0;
      pcnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      valid_q     <= '0;
      plot_q      <= '0;
      vcnt_q      <= '0;
      pcnt_q      <= '0;
      tick_q      <= '0;
      out_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      inv_seen_q  <= 1'b0;
      have_min_q  <= 1'b0;
      cleared_q   <= 1'b0;
      found_idx_q <= '0;
      inv_idx_q   <= '0;
      min_idx_q   <= '0;
      min_stamp_q <= '0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      plot_q    <= plot_d;
      vcnt_q    <= vcnt_d;
      pcnt_q    <= pcnt_d;
      cmp_vld_q <= ram_rd_en;
      cmp_idx_q <= scan_q;
      if (ram_rd_en) begin
        scan_q <= scan_q + IDX_W'(1);
      end
      if (accept) begin
        scan_q     <= '0;
        found_q    <= 1'b0;
        inv_seen_q <= 1'b0;
        have_min_q <= 1'b0;
        cleared_q  <= 1'b0;
      end
      if (cmp_vld_q) begin
        if (cmp_slot_v && cmp_match && !found_q) begin
          found_q     <= 1'b1;
          found_idx_q <= cmp_idx_q;
        end
        if (!cmp_slot_v && !inv_seen_q) begin
          inv_seen_q <= 1'b1;
          inv_idx_q  <= cmp_idx_q;
        end
        if (cmp_slot_v && (!have_min_q || (rd_entry.stamp < min_stamp_q))) begin
          have_min_q  <= 1'b1;
          min_idx_q   <= cmp_idx_q;
          min_stamp_q <= rd_entry.stamp;
        end
      end
      if (inv_hit) begin
        cleared_q <= 1'b1;
      end
      if (commit_go && pub_ok) begin
        tick_q <= tick_next;
      end
      if (commit_go) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= op_e'(s_axis_tuser);
      key_q       <= s_axis_tdata[KEY_W-1:0];
      rdy_q       <= s_axis_tdata[KEY_W];
      tag_q       <= s_axis_tdata[KEY_W+1];
      with_plot_q <= s_axis_tdata[KEY_W+2];
    end
    if (commit_go) begin
      res_status_q <= status_c;
      res_idx_q    <= pub_ok ? pick : '0;
      res_hit_q    <= pub_ok && found_q;
      res_evict_q  <= pub_ok && do_evict;
      res_clr_q    <= cleared_c;
      res_vcnt_q   <= vcnt_d;
      res_pcnt_q   <= pcnt_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_status_q;
  assign m_axis_tdata  = {2'b00, 4'(res_pcnt_q), 4'(res_vcnt_q), res_clr_q, res_evict_q,
                          res_hit_q, 3'(res_idx_q)};

endmodule

`default_nettype wire

// ===== rtl/core/kscl_checker.sv =====
// ----------------------------------------------------------------------------
// kscl_checker
// Port-level checks of the keyed slot cache results.
// ----------------------------------------------------------------------------
`default_nettype none

module kscl_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [kscl_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input wire logic [kscl_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [kscl_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [kscl_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  import kscl_pkg::*;

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ (^s_axis_tuser);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A successful publish leaves at least one valid slot.
  a_pub_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_PUBLISHED) |-> (m_axis_tdata[9:6] != 4'd0))
    else $error("publish reported no valid slot");

  // Plotted slots are a subset of valid slots.
  a_plot_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[13:10] <= m_axis_tdata[9:6]))
    else $error("plot count exceeds valid count");

  // Only a successful publish reports a slot, a hit or an eviction.
  a_non_pub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_PUBLISHED) |->
      (m_axis_tdata[4:0] == 5'd0))
    else $error("refused or invalidate result reports a slot");

  // A publish is never a hit and an eviction at once, and clears nothing.
  a_hit_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_PUBLISHED) |->
      !(m_axis_tdata[3] && m_axis_tdata[4]) && !m_axis_tdata[5])
    else $error("publish reported hit and eviction or a clear");

endmodule

bind keyed_slot_cache_lru kscl_checker u_kscl_checker (.*);

`default_nettype wire

// ===== verif/keyed_slot_cache_lru_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_slot_cache_lru_tb
// Self-checking bench for the keyed slot cache with LRU replacement.
// Directed requests cover refused publishes, filling the table, hits,
// evictions and both kinds of invalidation. Random traffic over a small key
// pool follows, first with request gaps and result stalls, then without.
// Each result is checked field by field against a behavioral model.
// ----------------------------------------------------------------------------

module keyed_slot_cache_lru_tb;
  import kscl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 2 * (SLOT_COUNT + 3);
  localparam int KEY_POOL_N = 12;

  typedef struct {
    op_e              op;
    logic [KEY_W-1:0] key;
    logic             ready;
    logic             tag;
    logic             plot;
  } cache_req_t;

  typedef struct {
    status_e          status;
    logic [IDX_W-1:0] slot;
    logic             hit;
    logic             evicted;
    logic             cleared;
    logic [CNT_W-1:0] valid_n;
    logic [CNT_W-1:0] plot_n;
  } cache_resp_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  logic                 cached_valid [SLOT_COUNT];
  logic [KEY_W-1:0]     cached_key   [SLOT_COUNT];
  logic [STAMP_W-1:0]   cached_stamp [SLOT_COUNT];
  logic                 cached_plot  [SLOT_COUNT];
  logic [STAMP_W-1:0]   publish_tick;

  cache_resp_t          expected_q [$];
  logic [KEY_W-1:0]     key_pool [KEY_POOL_N];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  request_count = 0;
  int  publish_count = 0;
  int  hit_count = 0;
  int  evict_count = 0;
  int  refused_count = 0;
  int  cleared_count = 0;
  bit  sender_gaps = 1'b1;
  bit  sink_stalls = 1'b1;
  int  stall_left = 0;

  keyed_slot_cache_lru uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!sink_stalls) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic cache_resp_t predict_cache_response(input cache_req_t req);
    cache_resp_t rsp;
    int          pick;
    int          vn;
    int          pn;
    bit          found;
    bit          free_seen;
    rsp.status  = ST_INV_DONE;
    rsp.slot    = '0;
    rsp.hit     = 1'b0;
    rsp.evicted = 1'b0;
    rsp.cleared = 1'b0;
    case (req.op)
      OP_PUBLISH: begin
        if (!req.ready) begin
          rsp.status = ST_NOT_READY;
        end else if (!req.tag) begin
          rsp.status = ST_NO_TAG;
        end else if (req.key == '0) begin
          rsp.status = ST_ZERO_KEY;
        end else begin
          pick = 0;
          found = 1'b0;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!found && cached_valid[i] && cached_key[i] == req.key) begin
              pick = i;
              found = 1'b1;
            end
          end
          if (found) begin
            rsp.hit = 1'b1;
          end else begin
            free_seen = 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (!free_seen) begin
                if (!cached_valid[i]) begin
                  pick = i;
                  free_seen = 1'b1;
                end else if (cached_stamp[i] < cached_stamp[pick]) begin
                  pick = i;
                end
              end
            end
            rsp.evicted = cached_valid[pick];
          end
          cached_valid[pick] = 1'b1;
          cached_key[pick]   = req.key;
          cached_plot[pick]  = req.plot;
          publish_tick       = publish_tick + 1'b1;
          cached_stamp[pick] = publish_tick;
          rsp.status = ST_PUBLISHED;
          rsp.slot   = pick[IDX_W-1:0];
        end
      end
      OP_INV_KEY, OP_INV_ALL: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (cached_valid[i] && (req.op == OP_INV_ALL || cached_key[i] == req.key)) begin
            cached_valid[i] = 1'b0;
            cached_key[i]   = '0;
            cached_plot[i]  = 1'b0;
            rsp.cleared     = 1'b1;
          end
        end
      end
      default: ;
    endcase
    vn = 0;
    pn = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (cached_valid[i]) begin
        vn++;
        if (cached_plot[i]) pn++;
      end
    end
    rsp.valid_n = vn[CNT_W-1:0];
    rsp.plot_n  = pn[CNT_W-1:0];
    if (rsp.status == ST_PUBLISHED) begin
      publish_count++;
      if (rsp.hit) hit_count++;
      if (rsp.evicted) evict_count++;
    end else if (req.op == OP_PUBLISH) begin
      refused_count++;
    end
    if (rsp.cleared) cleared_count++;
    return rsp;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("Mismatch at %0t in %s: expected 0x%0h, got 0x%0h", $realtime, name,
                 want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    cache_resp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result at %0t: tuser 0x%0h tdata 0x%0h", $realtime,
                   m_axis_tuser, m_axis_tdata);
      end else begin
        want = expected_q.pop_front();
        check_field("status", 16'(want.status), 16'(m_axis_tuser));
        check_field("slot_index", 16'(want.slot), 16'(m_axis_tdata[2:0]));
        check_field("hit", 16'(want.hit), 16'(m_axis_tdata[3]));
        check_field("evicted", 16'(want.evicted), 16'(m_axis_tdata[4]));
        check_field("any_cleared", 16'(want.cleared), 16'(m_axis_tdata[5]));
        check_field("valid_count", 16'(want.valid_n), 16'(m_axis_tdata[9:6]));
        check_field("plot_count", 16'(want.plot_n), 16'(m_axis_tdata[13:10]));
        check_field("tdata padding", 16'(0), 16'(m_axis_tdata[15:14]));
      end
    end
  end

  // The valid stays high after a handshake so back-to-back requests need no
  // second assignment in the same step; release_request lowers it.
  task automatic send_request(input cache_req_t req);
    int gap;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, req.plot, req.tag, req.ready, req.key};
    s_axis_tuser  <= req.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(predict_cache_response(req));
    request_count++;
  endtask

  task automatic release_request();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_fields(input op_e op, input logic [KEY_W-1:0] key, input logic ready,
                             input logic tag, input logic plot);
    cache_req_t req;
    req.op    = op;
    req.key   = key;
    req.ready = ready;
    req.tag   = tag;
    req.plot  = plot;
    send_request(req);
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[KEY_W-1:0];
  endfunction

  function automatic cache_req_t make_random_request();
    cache_req_t req;
    int         r;
    r = $urandom_range(0, 99);
    req.op    = OP_PUBLISH;
    req.ready = $urandom_range(0, 1);
    req.tag   = $urandom_range(0, 1);
    req.plot  = $urandom_range(0, 1);
    req.key   = ($urandom_range(0, 9) == 0) ? random_key()
                                            : key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    if (r < 60) begin
      req.ready = 1'b1;
      req.tag   = 1'b1;
      if (req.key == '0) req.key = 48'h1;
    end else if (r < 72) begin
      req.op = OP_INV_KEY;
      if ($urandom_range(0, 7) == 0) req.key = '0;
    end else if (r < 75) begin
      req.op = OP_INV_ALL;
    end else if (r < 90) begin
      if ($urandom_range(0, 2) == 0) req.key = '0;
      if (req.ready && req.tag) req.key = '0;
    end else begin
      req.op = OP_NONE;
    end
    return req;
  endfunction

  task automatic test_refused_publish();
    send_fields(OP_PUBLISH, 48'h0000_0000_1234, 1'b0, 1'b1, 1'b1);
    send_fields(OP_PUBLISH, '0, 1'b0, 1'b0, 1'b0);
    send_fields(OP_PUBLISH, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1);
    send_fields(OP_PUBLISH, '0, 1'b1, 1'b1, 1'b1);
    send_fields(OP_NONE, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_fill_and_evict();
    send_fields(OP_PUBLISH, 48'h0000_0000_0001, 1'b1, 1'b1, 1'b0);
    send_fields(OP_PUBLISH, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1);
    send_fields(OP_PUBLISH, 48'h5555_5555_5555, 1'b1, 1'b1, 1'b0);
    send_fields(OP_PUBLISH, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b1, 1'b1);
    send_fields(OP_PUBLISH, 48'h8000_0000_0000, 1'b1, 1'b1, 1'b0);
    send_fields(OP_PUBLISH, 48'h0190_0000_0001, 1'b1, 1'b1, 1'b1);
    send_fields(OP_PUBLISH, 48'h0190_0000_0002, 1'b1, 1'b1, 1'b1);
    send_fields(OP_PUBLISH, 48'h0190_0000_0003, 1'b1, 1'b1, 1'b0);
    send_fields(OP_PUBLISH, 48'h0000_0000_0001, 1'b1, 1'b1, 1'b1);
    send_fields(OP_PUBLISH, 48'h0190_0000_0004, 1'b1, 1'b1, 1'b1);
    send_fields(OP_PUBLISH, 48'h0190_0000_0005, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_invalidate();
    send_fields(OP_INV_KEY, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0);
    send_fields(OP_INV_KEY, 48'h0000_0000_0123, 1'b1, 1'b1, 1'b1);
    send_fields(OP_INV_KEY, '0, 1'b1, 1'b0, 1'b1);
    send_fields(OP_INV_ALL, 48'h0190_0000_0004, 1'b0, 1'b1, 1'b0);
    send_fields(OP_INV_ALL, '0, 1'b1, 1'b1, 1'b1);
    send_fields(OP_PUBLISH, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_request(make_random_request());
  endtask

  task automatic test_pause_until_drained();
    test_random_traffic(15);
    release_request();
    while (expected_q.size() != 0) @(posedge clk_i);
    test_random_traffic(15);
  endtask

  initial begin
    publish_tick = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      cached_valid[i] = 1'b0;
      cached_key[i]   = '0;
      cached_stamp[i] = '0;
      cached_plot[i]  = 1'b0;
    end
    for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = random_key() | 48'h1;
    key_pool[0] = 48'hFFFF_FFFF_FFFF;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_refused_publish();
    test_fill_and_evict();
    test_invalidate();
    test_random_traffic(400);
    test_pause_until_drained();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_random_traffic(400);

    release_request();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests: %0d publishes with %0d hits and %0d evictions,",
             request_count, publish_count, hit_count, evict_count);
    $display("%0d refused publishes, %0d invalidations that cleared slots, %0d mismatches.",
             refused_count, cleared_count, mismatch_count);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
